>>> rtl/core/cmrm_pkg.sv
// ----------------------------------------------------------------------------
// cmrm_pkg
// shared types, codes and the id compare function of the receive matcher
// ----------------------------------------------------------------------------
package cmrm_pkg;

  localparam int MAILBOXES_DEFAULT = 96;
  localparam int ID_W   = 29;
  localparam int IDX_W  = 7;
  localparam int STD_W  = 11;
  localparam int STD_SHIFT = 18;

  localparam logic [ID_W-1:0] ID_ALL = 29'h1fffffff;

  localparam logic [1:0] OP_FRAME = 2'd0;
  localparam logic [1:0] OP_SETUP = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;
  localparam logic [1:0] OP_CLEAR = 2'd3;

  localparam logic [3:0] CODE_RX_INACTIVE = 4'd0;
  localparam logic [3:0] CODE_RX_FULL     = 4'd2;
  localparam logic [3:0] CODE_RX_EMPTY    = 4'd4;

  localparam logic [1:0] REG_DEVICE_READY = 2'd0;
  localparam logic [1:0] REG_IMASK_EN     = 2'd1;
  localparam logic [1:0] REG_FIFO_EN      = 2'd2;
  localparam logic [1:0] REG_FIFO_MASK    = 2'd3;

  typedef struct packed {
    logic [1:0]      opcode;
    logic [IDX_W-1:0] buffer_index;
    logic [3:0]      buffer_code;
    logic            extended;
    logic [ID_W-1:0] ident;
    logic [ID_W-1:0] accept_mask;
    logic            frame_fd;
    logic            frame_brs;
    logic [3:0]      frame_dlc;
    logic [63:0]     payload;
    logic [15:0]     timestamp;
  } item_t;

  typedef struct packed {
    logic            accepted;
    logic [IDX_W-1:0] hit_index;
    logic            via_fifo;
    logic [3:0]      out_code;
    logic [3:0]      out_dlc;
    logic            out_fd;
    logic            out_brs;
    logic [63:0]     out_payload;
    logic [15:0]     out_timestamp;
    logic            out_flag;
    logic            fifo_available;
  } result_t;

  // buffer control word, code in the top bits
  typedef struct packed {
    logic [3:0]  code;
    logic        brs;
    logic        fd;
    logic        ide;
    logic [3:0]  dlc;
    logic [15:0] ts;
  } ctrl_t;

  typedef struct packed {
    logic            device_ready;
    logic            imask_en;
    logic            fifo_en;
    logic [ID_W-1:0] fifo_mask;
  } cfg_t;

  function automatic logic masked_match(logic [ID_W-1:0] bid, logic [ID_W-1:0] fid,
                                        logic ext, logic [ID_W-1:0] mask);
    logic [ID_W-1:0] f;
    f = ext ? fid : {fid[STD_W-1:0], {STD_SHIFT{1'b0}}};
    return (bid & mask) == (f & mask);
  endfunction

endpackage

>>> rtl/core/cmrm_if.sv
// ----------------------------------------------------------------------------
// cmrm_item_if / cmrm_result_if
// valid/ready channels for items and results
// ----------------------------------------------------------------------------
interface cmrm_item_if import cmrm_pkg::*; ();
  logic  valid;
  logic  ready;
  item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface cmrm_result_if import cmrm_pkg::*; ();
  logic    valid;
  logic    ready;
  result_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> rtl/core/cmrm_front.sv
// ----------------------------------------------------------------------------
// cmrm_front
// two-entry item queue between the input channel and the engine
// ----------------------------------------------------------------------------
module cmrm_front import cmrm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  cmrm_item_if.sink   item,
  output logic        q_valid,
  output item_t       q_item,
  input  logic        q_pop
);

  item_t      entry [2];
  logic       wp;
  logic       rp;
  logic [1:0] cnt;
  logic       push;

  assign item.ready = (cnt != 2'd2);
  assign push       = item.valid && item.ready;
  assign q_valid    = (cnt != 2'd0);
  assign q_item     = entry[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wp] <= item.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) begin
        wp <= ~wp;
      end
      if (q_pop) begin
        rp <= ~rp;
      end
      cnt <= cnt + 2'(push) - 2'(q_pop);
    end
  end

endmodule

>>> rtl/core/cmrm_engine.sv
// ----------------------------------------------------------------------------
// cmrm_engine
// buffer table, fifo check, one-buffer-per-cycle scan and result register
// ----------------------------------------------------------------------------
module cmrm_engine import cmrm_pkg::*; #(
  parameter int MAILBOXES = MAILBOXES_DEFAULT
) (
  input  logic         clk,
  input  logic         rst,
  input  cfg_t         cfg,
  input  logic         q_valid,
  input  item_t        q_item,
  output logic         q_pop,
  cmrm_result_if.source result
);

  localparam int AW = (MAILBOXES > 1) ? $clog2(MAILBOXES) : 1;
  localparam logic [AW-1:0] LAST = AW'(MAILBOXES - 1);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_DISP = 5'b00010,
    S_FIFO = 5'b00100,
    S_SCAN = 5'b01000,
    S_READ = 5'b10000
  } state_t;

  state_t state, state_next;
  item_t  cur;

  ctrl_t           ctrl_mem  [MAILBOXES];
  logic [ID_W-1:0] ident_mem [MAILBOXES];
  logic [ID_W-1:0] mask_mem  [MAILBOXES];
  logic [63:0]     data_mem  [MAILBOXES];

  logic [MAILBOXES-1:0] vld_setup;
  logic [MAILBOXES-1:0] vld_data;
  logic [MAILBOXES-1:0] flag;
  logic                 fifo_flag;

  logic [AW-1:0]   rd_addr;
  ctrl_t           rd_ctrl;
  logic [ID_W-1:0] rd_ident;
  logic [ID_W-1:0] rd_mask;
  logic [63:0]     rd_data;
  logic            rd_vld;
  logic            rd_dvld;

  logic [AW-1:0] cmp, cmp_next;

  logic          wr_ctrl_en, wr_id_en, wr_data_en;
  logic [AW-1:0] wr_addr;
  ctrl_t         wr_ctrl;
  logic          flag_set, flag_clr, ff_set, ff_clr;

  logic    res_valid;
  result_t res, res_next;
  logic    res_load;

  logic            idx_ok;
  logic [AW-1:0]   a;
  ctrl_t           rc;
  logic [ID_W-1:0] bid;
  logic [ID_W-1:0] bmask;
  logic            fifo_hit, scan_hit, m;
  ctrl_t           filled;

  assign q_pop  = (state == S_IDLE) && q_valid && !res_valid;
  assign idx_ok = ({1'b0, cur.buffer_index} < 8'(MAILBOXES));
  assign a      = cur.buffer_index[AW-1:0];

  // entries never set up read as reset contents
  always_comb begin
    rc    = rd_vld ? rd_ctrl : '{code: CODE_RX_INACTIVE, default: '0};
    bid   = rd_vld ? rd_ident : '0;
    bmask = rd_vld ? rd_mask : '0;
    filled      = rc;
    filled.code = CODE_RX_FULL;
    filled.dlc  = cur.frame_dlc;
    filled.fd   = cur.frame_fd;
    filled.brs  = cur.frame_fd && cur.frame_brs;
    fifo_hit = cfg.fifo_en && (rc.code == CODE_RX_EMPTY)
               && ((cfg.fifo_mask == '0)
                   || masked_match(bid, cur.ident, cur.extended, cfg.fifo_mask));
    m = (cfg.imask_en && (bmask != '0)) ? masked_match(bid, cur.ident, rc.ide, bmask)
                                        : masked_match(bid, cur.ident, rc.ide, ID_ALL);
    scan_hit = (rc.code == CODE_RX_EMPTY) && (m || (bid == '0));
  end

  always_comb begin
    state_next = state;
    cmp_next   = cmp;
    rd_addr    = '0;
    wr_ctrl_en = 1'b0;
    wr_id_en   = 1'b0;
    wr_data_en = 1'b0;
    wr_addr    = '0;
    wr_ctrl    = filled;
    flag_set   = 1'b0;
    flag_clr   = 1'b0;
    ff_set     = 1'b0;
    ff_clr     = 1'b0;
    res_load   = 1'b0;
    res_next   = '0;
    unique case (state)
      S_IDLE: begin
        if (q_pop) begin
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        unique case (cur.opcode)
          OP_FRAME: begin
            if (cfg.device_ready) begin
              state_next = S_FIFO;
            end else begin
              res_load = 1'b1;
            end
          end
          OP_SETUP: begin
            if (idx_ok) begin
              wr_ctrl_en = 1'b1;
              wr_id_en   = 1'b1;
              wr_addr    = a;
              wr_ctrl    = '{code: cur.buffer_code, ide: cur.extended, default: '0};
            end
            res_load = 1'b1;
          end
          OP_READ: begin
            if (idx_ok) begin
              rd_addr    = a;
              state_next = S_READ;
            end else begin
              res_load           = 1'b1;
              res_next.hit_index = cur.buffer_index;
            end
          end
          OP_CLEAR: begin
            if (idx_ok) begin
              flag_clr = 1'b1;
              wr_addr  = a;
              ff_clr   = (cur.buffer_index == '0);
            end
            res_load = 1'b1;
          end
          default: ;
        endcase
      end
      S_FIFO: begin
        if (fifo_hit) begin
          wr_ctrl_en = 1'b1;
          wr_data_en = 1'b1;
          flag_set   = 1'b1;
          ff_set     = 1'b1;
          res_load   = 1'b1;
          res_next.accepted = 1'b1;
          res_next.via_fifo = 1'b1;
        end else begin
          cmp_next   = '0;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_hit) begin
          wr_ctrl_en = 1'b1;
          wr_data_en = 1'b1;
          wr_addr    = cmp;
          wr_ctrl.ts = cur.timestamp;
          flag_set   = 1'b1;
          res_load   = 1'b1;
          res_next.accepted  = 1'b1;
          res_next.hit_index = IDX_W'(cmp);
        end else if (cmp == LAST) begin
          res_load = 1'b1;
        end else begin
          cmp_next = AW'(cmp + 1'b1);
          rd_addr  = cmp_next;
        end
      end
      S_READ: begin
        res_load = 1'b1;
        res_next.hit_index     = cur.buffer_index;
        res_next.out_code      = rc.code;
        res_next.out_dlc       = rc.dlc;
        res_next.out_fd        = rc.fd;
        res_next.out_brs       = rc.brs;
        res_next.out_timestamp = rc.ts;
        res_next.out_payload   = rd_dvld ? rd_data : '0;
        res_next.out_flag      = flag[a];
      end
      default: ;
    endcase
    if (res_load) begin
      state_next = S_IDLE;
    end
    res_next.fifo_available = ff_set ? 1'b1 : (ff_clr ? 1'b0 : fifo_flag);
  end

  always_ff @(posedge clk) begin
    rd_ctrl  <= ctrl_mem[rd_addr];
    rd_ident <= ident_mem[rd_addr];
    rd_mask  <= mask_mem[rd_addr];
    rd_data  <= data_mem[rd_addr];
    rd_vld   <= vld_setup[rd_addr];
    rd_dvld  <= vld_data[rd_addr];
    if (wr_ctrl_en) begin
      ctrl_mem[wr_addr] <= wr_ctrl;
    end
    if (wr_id_en) begin
      ident_mem[wr_addr] <= cur.ident;
      mask_mem[wr_addr]  <= cur.accept_mask;
    end
    if (wr_data_en) begin
      data_mem[wr_addr] <= cur.payload;
    end
    if (q_pop) begin
      cur <= q_item;
    end
    if (res_load) begin
      res <= res_next;
    end
    cmp <= cmp_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      vld_setup <= '0;
      vld_data  <= '0;
      flag      <= '1;
      fifo_flag <= 1'b1;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (wr_id_en) begin
        vld_setup[wr_addr] <= 1'b1;
      end
      if (wr_data_en) begin
        vld_data[wr_addr] <= 1'b1;
      end
      if (flag_set) begin
        flag[wr_addr] <= 1'b1;
      end else if (flag_clr) begin
        flag[wr_addr] <= 1'b0;
      end
      if (ff_set) begin
        fifo_flag <= 1'b1;
      end else if (ff_clr) begin
        fifo_flag <= 1'b0;
      end
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  assign result.valid = res_valid;
  assign result.data  = res;

`ifndef SYNTHESIS
  a_fifo_into_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.via_fifo |-> res.accepted && (res.hit_index == '0))
    else $error("fifo transfer not into buffer zero");
  a_pop_when_free: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !res_valid && (state == S_IDLE))
    else $error("item taken while result pending");
  a_scan_range: assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN |-> cmp <= LAST)
    else $error("scan index out of range");
`endif

endmodule

>>> rtl/core/can_mailbox_receive_matcher.sv
// ----------------------------------------------------------------------------
// can_mailbox_receive_matcher
// receive acceptance filter over a table of message buffers
// ----------------------------------------------------------------------------
// One item is handled at a time. Setup, clear, out-of-range reads and frames
// dropped while the device is not ready finish in the dispatch state, a read
// in the read state after it, a buffer 0 fifo transfer in the fifo state, and
// a scan-path frame in the scan state, which steps from buffer 0 up to the one
// that takes it (the last buffer when none does): the scan compares one buffer
// per cycle through a single read port of the buffer table. A two-entry queue
// takes new items while the engine works, and the result register holds one
// result until transferred. No clearing pass after reset.
module can_mailbox_receive_matcher import cmrm_pkg::*; #(
  parameter int MAILBOXES = MAILBOXES_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  cmrm_item_if.sink     item,
  cmrm_result_if.source result,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [3:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);

  cfg_t  cfg;
  logic  q_valid;
  item_t q_item;
  logic  q_pop;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{device_ready: 1'b0, imask_en: 1'b1, fifo_en: 1'b0, fifo_mask: '0};
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        REG_DEVICE_READY: cfg.device_ready <= pwdata[0];
        REG_IMASK_EN:     cfg.imask_en     <= pwdata[0];
        REG_FIFO_EN:      cfg.fifo_en      <= pwdata[0];
        REG_FIFO_MASK:    cfg.fifo_mask    <= pwdata[ID_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_DEVICE_READY: prdata = {31'd0, cfg.device_ready};
      REG_IMASK_EN:     prdata = {31'd0, cfg.imask_en};
      REG_FIFO_EN:      prdata = {31'd0, cfg.fifo_en};
      REG_FIFO_MASK:    prdata = {3'd0, cfg.fifo_mask};
      default:          prdata = '0;
    endcase
  end

  cmrm_front u_front (
    .clk     (clk),
    .rst     (rst),
    .item    (item),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop)
  );

  cmrm_engine #(.MAILBOXES(MAILBOXES)) u_engine (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop),
    .result  (result)
  );

endmodule
